>>> src/yhr_pkg.sv
// Shared constants, types and coefficient helper for the YIQ hue rotation block.
`timescale 1ns / 1ps
`default_nettype none
package yhr_pkg;

  localparam int COEFF_FRACTION_BITS_DEF = 14;
  localparam int ROT_BITS  = 14;   // fraction bits of the cosine and sine registers
  localparam int CHAN_W    = 8;
  localparam int PIX_W     = 3 * CHAN_W;
  localparam int TRIG_W    = 16;
  localparam int NUM_STAGES = 5;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_COSINE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SINE   = 1'b1;

  localparam logic signed [TRIG_W-1:0] COSINE_RESET = 16'sd16384;
  localparam logic signed [TRIG_W-1:0] SINE_RESET   = 16'sd0;

  typedef logic [NUM_STAGES-1:0] yhr_stage_en_t;

  // Quantize a coefficient given in thousandths, halves away from zero.
  function automatic longint coeff(input longint milli, input int frac);
    longint mag;
    longint q;
    mag = (milli < 0) ? -milli : milli;
    q   = ((mag << frac) + 64'sd500) / 64'sd1000;
    return (milli < 0) ? -q : q;
  endfunction

endpackage
`default_nettype wire

>>> src/yhr_datapath.sv
// Five-stage arithmetic datapath: RGB to YIQ, I/Q rotation, YIQ to RGB with clamp.
`timescale 1ns / 1ps
`default_nettype none
module yhr_datapath #(
  parameter int COEFF_FRACTION_BITS = yhr_pkg::COEFF_FRACTION_BITS_DEF
) (
  input  logic                               clk,
  input  yhr_pkg::yhr_stage_en_t             stage_en,
  input  logic [yhr_pkg::PIX_W-1:0]          pix_in,
  input  logic signed [yhr_pkg::TRIG_W-1:0]  cosine,
  input  logic signed [yhr_pkg::TRIG_W-1:0]  sine,
  output logic [yhr_pkg::PIX_W-1:0]          pix_out
);
  import yhr_pkg::*;

  localparam int F   = COEFF_FRACTION_BITS;
  localparam int CW  = F + 2;             // coefficient width
  localparam int YW  = F + 10;            // Y, I, Q width
  localparam int YS  = F + 13;            // forward sum before trim
  localparam int PW  = TRIG_W + YW;       // rotation product width
  localparam int RFW = PW + 1;            // rotation sum width
  localparam int RW  = RFW - ROT_BITS;    // rotated I, Q width
  localparam int MW  = CW + RW;           // inverse product width
  localparam int AW  = MW + 2;            // channel accumulator width

  localparam logic signed [CW-1:0] KYR = CW'(coeff(299, F));
  localparam logic signed [CW-1:0] KYG = CW'(coeff(587, F));
  localparam logic signed [CW-1:0] KYB = CW'(coeff(114, F));
  localparam logic signed [CW-1:0] KIR = CW'(coeff(596, F));
  localparam logic signed [CW-1:0] KIG = CW'(coeff(-274, F));
  localparam logic signed [CW-1:0] KIB = CW'(coeff(-321, F));
  localparam logic signed [CW-1:0] KQR = CW'(coeff(211, F));
  localparam logic signed [CW-1:0] KQG = CW'(coeff(-523, F));
  localparam logic signed [CW-1:0] KQB = CW'(coeff(311, F));

  // inverse matrix, I and Q columns; the Y column is exactly one
  localparam logic signed [CW-1:0] KI [3] = '{CW'(coeff(956, F)),
                                              CW'(coeff(-272, F)),
                                              CW'(coeff(-1107, F))};
  localparam logic signed [CW-1:0] KQ [3] = '{CW'(coeff(621, F)),
                                              CW'(coeff(-647, F)),
                                              CW'(coeff(1705, F))};

  localparam logic signed [RFW-1:0] HALF = RFW'(1) <<< (ROT_BITS - 1);

  // stage 1: forward matrix
  logic signed [CHAN_W:0] r9, g9, b9;
  logic signed [YS-1:0]   y_sum, i_sum, q_sum;
  logic signed [YW-1:0]   y1_r, i1_r, q1_r;

  always_comb begin
    r9    = $signed({1'b0, pix_in[CHAN_W-1:0]});
    g9    = $signed({1'b0, pix_in[2*CHAN_W-1:CHAN_W]});
    b9    = $signed({1'b0, pix_in[3*CHAN_W-1:2*CHAN_W]});
    y_sum = KYR * r9 + KYG * g9 + KYB * b9;
    i_sum = KIR * r9 + KIG * g9 + KIB * b9;
    q_sum = KQR * r9 + KQG * g9 + KQB * b9;
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      y1_r <= y_sum[YW-1:0];
      i1_r <= i_sum[YW-1:0];
      q1_r <= q_sum[YW-1:0];
    end
  end

  // stage 2: rotation products
  logic signed [YW-1:0] y2_r;
  logic signed [PW-1:0] pci_nxt, psq_nxt, psi_nxt, pcq_nxt;
  logic signed [PW-1:0] pci_r, psq_r, psi_r, pcq_r;

  always_comb begin
    pci_nxt = cosine * i1_r;
    psq_nxt = sine * q1_r;
    psi_nxt = sine * i1_r;
    pcq_nxt = cosine * q1_r;
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      y2_r  <= y1_r;
      pci_r <= pci_nxt;
      psq_r <= psq_nxt;
      psi_r <= psi_nxt;
      pcq_r <= pcq_nxt;
    end
  end

  // stage 3: rotation sums, round half up
  logic signed [RFW-1:0] ri_full, rq_full, ri_sh, rq_sh;
  logic signed [YW-1:0]  y3_r;
  logic signed [RW-1:0]  ri3_r, rq3_r;

  always_comb begin
    ri_full = pci_r - psq_r + HALF;
    rq_full = psi_r + pcq_r + HALF;
    ri_sh   = ri_full >>> ROT_BITS;
    rq_sh   = rq_full >>> ROT_BITS;
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      y3_r  <= y2_r;
      ri3_r <= ri_sh[RW-1:0];
      rq3_r <= rq_sh[RW-1:0];
    end
  end

  // stage 4: inverse matrix products
  logic signed [AW-1:0] yt_nxt, yt4_r;
  logic signed [MW-1:0] pi_nxt [3];
  logic signed [MW-1:0] pq_nxt [3];
  logic signed [MW-1:0] pi4_r  [3];
  logic signed [MW-1:0] pq4_r  [3];

  always_comb begin
    yt_nxt = {{(AW-YW-F){y3_r[YW-1]}}, y3_r, {F{1'b0}}};
    for (int k = 0; k < 3; k++) begin
      pi_nxt[k] = KI[k] * ri3_r;
      pq_nxt[k] = KQ[k] * rq3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      yt4_r <= yt_nxt;
      for (int k = 0; k < 3; k++) begin
        pi4_r[k] <= pi_nxt[k];
        pq4_r[k] <= pq_nxt[k];
      end
    end
  end

  // stage 5: accumulate, drop fraction, clamp
  logic signed [AW-1:0]     acc [3];
  logic [PIX_W-1:0]         pix_nxt, pix5_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = yt4_r + pi4_r[k] + pq4_r[k];
      if (acc[k][AW-1]) begin
        pix_nxt[k*CHAN_W +: CHAN_W] = '0;
      end else if (|acc[k][AW-2:2*F+CHAN_W]) begin
        pix_nxt[k*CHAN_W +: CHAN_W] = '1;
      end else begin
        pix_nxt[k*CHAN_W +: CHAN_W] = acc[k][2*F +: CHAN_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      pix5_r <= pix_nxt;
    end
  end

  assign pix_out = pix5_r;

endmodule
`default_nettype wire

>>> src/yiq_hue_rotate_pixel_top.sv
// Top level of the YIQ hue rotation block: stream channels, registers, stage control.
//
// Usage:
//   in_*   : pixel stream in; in_tdata = {blue, green, red}, red in bits 7:0.
//   out_*  : rotated pixel stream out, same packing.
//   cfg_*  : register writes; index 0 is the rotation cosine, index 1 the
//            rotation sine, both signed with 14 fraction bits. A write transfers
//            whenever cfg_valid is high (cfg_ready is tied high). Write only
//            while no pixel is in flight.
// Throughput: one pixel per clock while out_tready is high. The datapath is
//   five register stages (forward matrix, rotation products, rotation sums,
//   inverse products, accumulate and clamp), each holding one pixel.
// Order: a transferred pixel passes through the stages in the order listed
//   and shows on out_tvalid once it reaches the accumulate and clamp stage.
// Reset: rst_n low empties every stage, sets the cosine to 1.0 and the sine
//   to 0 (identity rotation up to rounding).
// Stall: each stage holds while it is full and the next one cannot take its
//   pixel; empty stages still fill, so in_tready falls only once all five
//   stages are full and out_tready is low. Nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
module yiq_hue_rotate_pixel_top #(
  parameter int COEFF_FRACTION_BITS = yhr_pkg::COEFF_FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [yhr_pkg::PIX_W-1:0]         in_tdata,   // red_in, green_in, blue_in
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [yhr_pkg::PIX_W-1:0]         out_tdata,  // red_out, green_out, blue_out
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [yhr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [yhr_pkg::TRIG_W-1:0]        cfg_data
);
  import yhr_pkg::*;

  // Registers: take every write at once.
  logic signed [TRIG_W-1:0] cos_r, cos_nxt, sin_r, sin_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cos_nxt = cos_r;
    sin_nxt = sin_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_COSINE: cos_nxt = cfg_data;
        REG_SINE:   sin_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r <= COSINE_RESET;
      sin_r <= SINE_RESET;
    end else begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  // Stage control: a stage loads when it is empty or its pixel moves on.
  logic [NUM_STAGES-1:0] v_r, v_nxt;
  logic [NUM_STAGES:0]   rdy;
  yhr_stage_en_t         stage_en;

  always_comb begin
    rdy[NUM_STAGES] = out_tready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    stage_en = rdy[NUM_STAGES-1:0];
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (stage_en[k]) begin
        v_nxt[k] = (k == 0) ? in_tvalid : v_r[(k == 0) ? 0 : k-1];
      end else begin
        v_nxt[k] = v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = v_r[NUM_STAGES-1];

  yhr_datapath #(
    .COEFF_FRACTION_BITS(COEFF_FRACTION_BITS)
  ) u_datapath (
    .clk      (clk),
    .stage_en (stage_en),
    .pix_in   (in_tdata),
    .cosine   (cos_r),
    .sine     (sin_r),
    .pix_out  (out_tdata)
  );

  // Input backpressure only when the whole pipe is full and the output stalls.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> ((&v_r) && !out_tready))
    else $error("in_tready low with room in the pipeline");

  // A full middle stage that cannot advance keeps its pixel.
  a_hold_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[2] && !rdy[3]) |=> v_r[2])
    else $error("stage 3 lost a pixel while stalled");

  // Registers change only through a write transfer.
  a_cfg_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_valid |=> ($stable(cos_r) && $stable(sin_r)))
    else $error("rotation register changed without a write");

endmodule
`default_nettype wire
